@@ hdl/mlu_pkg.sv @@
// ----------------------------------------------------------------------------
// mlu_pkg
// Shared types and codes for the 64-bit load unit: request and result
// layouts, load action codes and access size codes.
// ----------------------------------------------------------------------------
package mlu_pkg;

  typedef enum logic [3:0] {
    ACT_LB  = 4'd0,
    ACT_LBU = 4'd1,
    ACT_LH  = 4'd2,
    ACT_LHU = 4'd3,
    ACT_LW  = 4'd4,
    ACT_LWU = 4'd5,
    ACT_LWL = 4'd6,
    ACT_LWR = 4'd7,
    ACT_LD  = 4'd8,
    ACT_LDL = 4'd9,
    ACT_LDR = 4'd10
  } mlu_action_t;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_DWORD = 2'd3;

  typedef struct packed {
    logic [3:0]         action;
    logic [63:0]        base_value;
    logic signed [15:0] offset;
    logic [4:0]         dest_index;
    logic [63:0]        dest_old;
    logic [63:0]        mem_data;
  } mlu_req_t;

  typedef struct packed {
    logic [63:0] access_address;
    logic [1:0]  access_size;
    logic        write_enable;
    logic [63:0] write_value;
  } mlu_res_t;

endpackage

@@ hdl/mips64_load_unit_top.sv @@
// ----------------------------------------------------------------------------
// mips64_load_unit_top
// Load unit: effective address, access size and write-back value for
// byte/half/word/double loads, including the left/right merging forms.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------
//  load     | load_valid / load_stall     | load   (mlu_req_t)
//  result   | result_valid / result_stall | result (mlu_res_t)
//
//  One request per cycle unless a stalled result holds the pipe; a taken request
//  passes through the request register and then the result register.
//  The path between them is one 64-bit add followed by one byte shifter.
//  Reset (rst, synchronous) empties both registers.
//  A stalled result holds; the request register keeps taking requests while
//  the result register is free or being drained.
module mips64_load_unit_top
  import mlu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load_valid,
  output logic     load_stall,
  input  mlu_req_t load,
  output logic     result_valid,
  input  logic     result_stall,
  output mlu_res_t result
);

  logic     req_valid;
  mlu_req_t req;
  mlu_res_t res_next;
  logic     advance;

  logic [63:0] ea;
  logic [5:0]  sh_left_d;
  logic [5:0]  sh_right_d;
  logic [4:0]  sh_left_w;
  logic [4:0]  sh_right_w;
  logic [31:0] word_merge;
  logic [63:0] dword_merge;
  logic [63:0] value;
  logic        known;

  assign advance    = !result_valid || !result_stall;
  assign load_stall = req_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!load_stall) begin
      req_valid <= load_valid;
    end
    if (load_valid && !load_stall) begin
      req <= load;
    end
  end

  assign ea = req.base_value + {{48{req.offset[15]}}, req.offset};

  // Big-endian left/right shift amounts in bits.
  assign sh_left_w  = {ea[1:0], 3'b000};
  assign sh_right_w = {~ea[1:0], 3'b000};
  assign sh_left_d  = {ea[2:0], 3'b000};
  assign sh_right_d = {~ea[2:0], 3'b000};

  always_comb begin
    res_next.access_address = ea;
    res_next.access_size    = SIZE_BYTE;
    value       = '0;
    known       = 1'b1;
    word_merge  = '0;
    dword_merge = '0;
    case (req.action)
      ACT_LB: begin
        value = {{56{req.mem_data[7]}}, req.mem_data[7:0]};
      end
      ACT_LBU: begin
        value = {56'd0, req.mem_data[7:0]};
      end
      ACT_LH: begin
        res_next.access_size = SIZE_HALF;
        value = {{48{req.mem_data[15]}}, req.mem_data[15:0]};
      end
      ACT_LHU: begin
        res_next.access_size = SIZE_HALF;
        value = {48'd0, req.mem_data[15:0]};
      end
      ACT_LW: begin
        res_next.access_size = SIZE_WORD;
        value = {{32{req.mem_data[31]}}, req.mem_data[31:0]};
      end
      ACT_LWU: begin
        res_next.access_size = SIZE_WORD;
        value = {32'd0, req.mem_data[31:0]};
      end
      ACT_LD: begin
        res_next.access_size = SIZE_DWORD;
        value = req.mem_data;
      end
      ACT_LWL: begin
        res_next.access_size    = SIZE_WORD;
        res_next.access_address = {ea[63:2], 2'b00};
        // keep the old low bytes below the shifted-in data
        word_merge = (req.mem_data[31:0] << sh_left_w)
                   | (req.dest_old[31:0] & ~(32'hffff_ffff << sh_left_w));
        value = {{32{word_merge[31]}}, word_merge};
      end
      ACT_LWR: begin
        res_next.access_size    = SIZE_WORD;
        res_next.access_address = {ea[63:2], 2'b00};
        word_merge = (req.mem_data[31:0] >> sh_right_w)
                   | (req.dest_old[31:0] & ~(32'hffff_ffff >> sh_right_w));
        value = {{32{word_merge[31]}}, word_merge};
      end
      ACT_LDL: begin
        res_next.access_size    = SIZE_DWORD;
        res_next.access_address = {ea[63:3], 3'b000};
        dword_merge = (req.mem_data << sh_left_d)
                    | (req.dest_old & ~(64'hffff_ffff_ffff_ffff << sh_left_d));
        value = dword_merge;
      end
      ACT_LDR: begin
        res_next.access_size    = SIZE_DWORD;
        res_next.access_address = {ea[63:3], 3'b000};
        dword_merge = (req.mem_data >> sh_right_d)
                    | (req.dest_old & ~(64'hffff_ffff_ffff_ffff >> sh_right_d));
        value = dword_merge;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    res_next.write_enable = known && (req.dest_index != 5'd0);
    res_next.write_value  = res_next.write_enable ? value : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= req_valid;
    end
    if (advance && req_valid) begin
      result <= res_next;
    end
  end

endmodule

@@ hdl/mlu_checker.sv @@
// ----------------------------------------------------------------------------
// mlu_checker
// Port-level checks for the load unit, bound to the top level.
// ----------------------------------------------------------------------------
module mlu_checker
  import mlu_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     load_valid,
  input logic     load_stall,
  input mlu_req_t load,
  input logic     result_valid,
  input logic     result_stall,
  input mlu_res_t result
);

  // A taken request shows up as a result (or is backed up behind one).
  a_req_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (load_valid && !load_stall) |=> ##1 result_valid)
    else $error("accepted request did not reach the result register");

  // Backpressure on the request side only comes from a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    load_stall |-> (result_valid && result_stall))
    else $error("request stalled while result side is free");

  // Suppressed writes carry a zero value.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.write_enable) |-> (result.write_value == 64'd0))
    else $error("write_value nonzero without write_enable");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind mips64_load_unit_top mlu_checker u_mlu_checker (
  .clk          (clk),
  .rst          (rst),
  .load_valid   (load_valid),
  .load_stall   (load_stall),
  .load         (load),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
